// ===== rtl/core/stuck_masked_hit_pad_decoder_macros.svh =====
// Assertion macros for the stuck-masked hit pad decoder.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef STUCK_MASKED_HIT_PAD_DECODER_MACROS_SVH
`define STUCK_MASKED_HIT_PAD_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SMHPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SMHPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/smhpd_pkg.sv =====
// Package for the stuck-masked hit pad decoder: sizes, codes and shared types.
// No dependencies; imported by the interfaces and every module of the block.
package smhpd_pkg;

  localparam int CHANNELS  = 64;
  localparam int PORTS     = 4;
  localparam int CH_W      = $clog2(CHANNELS);
  localparam int TBL_DEPTH = PORTS * CHANNELS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // Frame words keep only the implemented channels
  localparam logic [63:0] CHAN_MASK =
    (CHANNELS >= 64) ? {64{1'b1}} : ((64'd1 << CHANNELS) - 64'd1);

  localparam logic [6:0] FIFO_DEPTH_RST = 7'd15;
  localparam logic [7:0] PAD_NONE       = 8'd0;
  localparam logic [7:0] PAD_MULTI      = 8'd65;

  typedef enum logic {
    CMD_TABLE = 1'b0,
    CMD_FRAME = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    HIT_NONE  = 2'd0,
    HIT_ONE   = 2'd1,
    HIT_MULTI = 2'd2
  } hit_class_t;

  // Work item from front to back: a table write or a finished frame
  typedef struct packed {
    cmd_t            kind;
    logic [1:0]      port;
    logic [CH_W-1:0] ch;
    logic [7:0]      pad;
    hit_class_t      cls;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/core/smhpd_in_if.sv =====
// Input request channel of the pad decoder: valid/ready plus one input item.
// Depends on smhpd_pkg.
interface smhpd_in_if import smhpd_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        command;
  logic [1:0]  port;
  logic [5:0]  channel;
  logic [7:0]  pad_value;
  logic [63:0] fifo_word;

  modport source (output valid, command, port, channel, pad_value, fifo_word,
                  input ready);
  modport sink   (input valid, command, port, channel, pad_value, fifo_word,
                  output ready);
endinterface

// ===== rtl/core/smhpd_out_if.sv =====
// Result request channel of the pad decoder: valid/ready plus one result.
// Depends on smhpd_pkg.
interface smhpd_out_if import smhpd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] out_port;
  logic [7:0] pad_code;
  logic [1:0] hit_class;

  modport source (output valid, out_port, pad_code, hit_class, input ready);
  modport sink   (input valid, out_port, pad_code, hit_class, output ready);
endinterface

// ===== rtl/core/smhpd_front.sv =====
// Front end: accepts requests, tracks the frame and classifies its first hit.
// Depends on smhpd_pkg and smhpd_in_if; pushes work items into smhpd_queue.
module smhpd_front import smhpd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  smhpd_in_if.sink      in_req,
  input  logic          cfg_we,
  input  logic [6:0]    cfg_wdata,
  input  q_stat_t       q_stat,
  output logic          q_push,
  output q_entry_t      q_din
);

  logic [6:0]  depth_r;
  logic [6:0]  idx_r, idx_nxt;
  logic [63:0] mask_r, mask_nxt;
  logic [63:0] first_r, first_nxt;
  logic        seen_r, seen_nxt;

  logic           acc;
  logic           is_frame;
  logic           end_frame;
  logic [63:0]    word_in;
  logic [63:0]    live;
  logic           capture;
  logic [63:0]    first_eff;
  logic [63:0]    lowbit;
  logic [CH_W-1:0] enc;
  hit_class_t     cls;
  logic           chan_ok;

  assign in_req.ready = ~q_stat.full;
  assign acc       = in_req.valid & in_req.ready;
  assign is_frame  = (cmd_t'(in_req.command) == CMD_FRAME);
  assign end_frame = (idx_r >= depth_r);
  assign chan_ok   = ({1'b0, in_req.channel} < 7'(CHANNELS));

  // Masking and first-hit capture
  assign word_in = in_req.fifo_word & CHAN_MASK;
  assign live    = word_in & ~mask_r;
  assign capture = (idx_r != 7'd0) && !seen_r && (live != 64'd0);

  always_comb begin
    if (idx_r == 7'd0) begin
      first_eff = 64'd0;
    end else if (capture) begin
      first_eff = live;
    end else begin
      first_eff = first_r;
    end
  end

  // Classification: isolate lowest set bit, compare for multiple hits
  assign lowbit = first_eff & (~first_eff + 64'd1);

  always_comb begin
    enc = '0;
    for (int b = 0; b < 64; b++) begin
      if (lowbit[b]) begin
        enc = enc | CH_W'(b);
      end
    end
  end

  always_comb begin
    if (first_eff == 64'd0) begin
      cls = HIT_NONE;
    end else if (first_eff != lowbit) begin
      cls = HIT_MULTI;
    end else begin
      cls = HIT_ONE;
    end
  end

  // Frame state update
  always_comb begin
    idx_nxt   = idx_r;
    mask_nxt  = mask_r;
    first_nxt = first_r;
    seen_nxt  = seen_r;
    if (acc && is_frame) begin
      if (end_frame) begin
        idx_nxt   = 7'd0;
        mask_nxt  = 64'd0;
        first_nxt = 64'd0;
        seen_nxt  = 1'b0;
      end else begin
        idx_nxt = idx_r + 7'd1;
        if (idx_r == 7'd0) begin
          mask_nxt  = word_in;
          first_nxt = 64'd0;
          seen_nxt  = 1'b0;
        end else if (capture) begin
          first_nxt = live;
          seen_nxt  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= FIFO_DEPTH_RST;
      idx_r   <= 7'd0;
      mask_r  <= 64'd0;
      first_r <= 64'd0;
      seen_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        depth_r <= cfg_wdata;
      end
      idx_r   <= idx_nxt;
      mask_r  <= mask_nxt;
      first_r <= first_nxt;
      seen_r  <= seen_nxt;
    end
  end

  // Work item toward the back end
  always_comb begin
    q_push    = acc && (is_frame ? end_frame : chan_ok);
    q_din     = '0;
    q_din.port = in_req.port;
    if (is_frame) begin
      q_din.kind = CMD_FRAME;
      q_din.ch   = enc;
      q_din.cls  = cls;
    end else begin
      q_din.kind = CMD_TABLE;
      q_din.ch   = CH_W'(in_req.channel);
      q_din.pad  = in_req.pad_value;
      q_din.cls  = HIT_NONE;
    end
  end

endmodule

// ===== rtl/core/smhpd_queue.sv =====
// Short FIFO of work items between the front and back ends.
// Depends on smhpd_pkg.
module smhpd_queue import smhpd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t din,
  input  logic     pop,
  output q_entry_t dout,
  output q_stat_t  stat
);

  q_entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wptr_r, rptr_r;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign dout       = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= din;
    end
  end

endmodule

// ===== rtl/core/smhpd_back.sv =====
// Back end: holds the pad table, performs writes and lookups, drives results.
// Depends on smhpd_pkg and smhpd_out_if; pops work items from smhpd_queue.
module smhpd_back import smhpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  q_entry_t    q_dout,
  input  q_stat_t     q_stat,
  output logic        q_pop,
  smhpd_out_if.source out_req
);

  logic [7:0]  tbl_mem [TBL_DEPTH];
  logic [7:0]  rdata_r;
  logic [TBL_AW-1:0] tbl_idx;

  logic        s1_v_r, s1_v_nxt;
  logic [1:0]  s1_port_r;
  hit_class_t  s1_cls_r;

  logic        out_v_r, out_v_nxt;
  logic [1:0]  out_port_r;
  logic [7:0]  out_code_r, code_sel;
  hit_class_t  out_cls_r;

  logic        out_free, s1_free, s1_move;

  // Pipeline flow control
  assign out_free = !out_v_r || out_req.ready;
  assign s1_move  = s1_v_r && out_free;
  assign s1_free  = !s1_v_r || out_free;
  assign q_pop    = !q_stat.empty && s1_free;

  assign tbl_idx = TBL_AW'(TBL_AW'(q_dout.port % PORTS) * TBL_AW'(CHANNELS)
                   + TBL_AW'(q_dout.ch));

  // Pad table: write on table items, registered read on frame items
  always_ff @(posedge clk) begin
    if (q_pop && q_dout.kind == CMD_TABLE) begin
      tbl_mem[tbl_idx] <= q_dout.pad;
    end
    if (q_pop && q_dout.kind == CMD_FRAME) begin
      rdata_r <= tbl_mem[tbl_idx];
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s1_free) begin
      s1_v_nxt = q_pop && (q_dout.kind == CMD_FRAME);
    end
    out_v_nxt = out_v_r;
    if (out_free) begin
      out_v_nxt = s1_v_r;
    end
  end

  // Result code from class and table data
  always_comb begin
    case (s1_cls_r)
      HIT_NONE:  code_sel = PAD_NONE;
      HIT_ONE:   code_sel = rdata_r;
      HIT_MULTI: code_sel = PAD_MULTI;
      default:   code_sel = PAD_NONE;
    endcase
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop && s1_free) begin
      s1_port_r <= q_dout.port;
      s1_cls_r  <= q_dout.cls;
    end
    if (s1_move) begin
      out_port_r <= s1_port_r;
      out_code_r <= code_sel;
      out_cls_r  <= s1_cls_r;
    end
  end

  assign out_req.valid     = out_v_r;
  assign out_req.out_port  = out_port_r;
  assign out_req.pad_code  = out_code_r;
  assign out_req.hit_class = out_cls_r;

endmodule

// ===== rtl/core/stuck_masked_hit_pad_decoder.sv =====
// Stuck-masked hit pad decoder.
// Channels: in_req carries table-load requests (command 0: port, channel,
// pad_value) and frame words (command 1: fifo_word); out_req returns one
// result (out_port, pad_code, hit_class) per finished frame. cfg_we/cfg_wdata
// set the number of hit words after the stuck mask word (fifo_depth).
// Throughput: one request per cycle for both request kinds while the queue has room.
// Path: a result passes the front classifier, a 4-entry work queue, the
// registered pad-table read, and the output register.
// Reset: fifo_depth returns to 15, the frame restarts at the stuck mask word,
// and the queue and pipeline empty. The pad table is not cleared: a lookup
// of an entry that was never loaded returns an arbitrary pad.
// Receiver stall: results wait in the output register and lookup stage; the
// queue absorbs four more work items before in_req.ready drops. Frame words
// that do not end a frame are still taken only while the queue has room.
// Depends on smhpd_pkg, the channel interfaces and the front/queue/back units.
`include "stuck_masked_hit_pad_decoder_macros.svh"

module stuck_masked_hit_pad_decoder import smhpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  smhpd_in_if.sink    in_req,
  smhpd_out_if.source out_req,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);

  logic     q_push, q_pop;
  q_entry_t q_din, q_dout;
  q_stat_t  q_stat;

  // Front: accept and classify
  smhpd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  // Work queue
  smhpd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .stat  (q_stat)
  );

  // Back: table and results
  smhpd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_dout  (q_dout),
    .q_stat  (q_stat),
    .q_pop   (q_pop),
    .out_req (out_req)
  );

  // Checks
  `SMHPD_ASSERT_IMP(a_push_not_full, q_push, !q_stat.full, "push into full queue")
  `SMHPD_ASSERT_IMP(a_pop_not_empty, q_pop, !q_stat.empty, "pop from empty queue")
  `SMHPD_ASSERT_NXT(a_push_lands, q_push, !q_stat.empty, "pushed item lost")

endmodule

// ===== sim/stuck_masked_hit_pad_decoder_test.sv =====
// Self-checking bench for the stuck-masked hit pad decoder: table loads and frames
// go in, pad codes are predicted locally and checked in order.
// Depends on smhpd_pkg, smhpd_in_if, smhpd_out_if and stuck_masked_hit_pad_decoder.
module stuck_masked_hit_pad_decoder_test;
  import smhpd_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int LONG_HOLD       = 80;
  localparam int SETTLE_CYCLES   = 8;
  localparam int IDLE_PCT        = 27;
  localparam int MAX_PRINTS      = 40;

  typedef struct {
    cmd_t        command;
    logic [1:0]  port;
    logic [5:0]  channel;
    logic [7:0]  pad;
    logic [63:0] word;
  } decoder_req_t;

  typedef struct {
    logic [1:0] port;
    logic [7:0] pad;
    hit_class_t cls;
  } pad_result_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [6:0] cfg_wdata;

  smhpd_in_if  in_ch();
  smhpd_out_if out_ch();

  stuck_masked_hit_pad_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_ch),
    .out_req  (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Stimulus side
  decoder_req_t pending_reqs[$];
  bit           loaded [PORTS][CHANNELS];
  int           queued_items  = 0;
  int           hold_requests = 0;
  bit           steady        = 1'b0;

  // Predictor state
  logic [7:0]   tbl_pad [TBL_DEPTH];
  logic [63:0]  cur_mask;
  logic [63:0]  hit_word;
  bit           hit_found;
  logic [7:0]   word_pos;
  logic [6:0]   frame_depth = FIFO_DEPTH_RST;
  pad_result_t  pad_results_due[$];

  // Bookkeeping
  int error_count   = 0;
  int table_writes  = 0;
  int frame_words   = 0;
  int class_seen[3] = '{0, 0, 0};
  int idle_cycles   = 0;

  task automatic flag_mismatch(string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Expected result of one accepted request, if any
  task automatic predict_request(decoder_req_t r);
    logic [63:0] w;
    logic [63:0] live;
    pad_result_t res;
    int ch;
    if (r.command == CMD_TABLE) begin
      if (r.channel < CHANNELS) tbl_pad[(r.port % PORTS) * CHANNELS + r.channel] = r.pad;
      table_writes++;
      return;
    end
    frame_words++;
    w = r.word & CHAN_MASK;
    if (word_pos == 0) begin
      cur_mask  = w;
      hit_word  = '0;
      hit_found = 1'b0;
    end else if (!hit_found) begin
      live = w & ~cur_mask;
      if (live != 0) begin
        hit_word  = live;
        hit_found = 1'b1;
      end
    end
    if (word_pos < frame_depth) begin
      if (word_pos < 8'd255) word_pos++;
      return;
    end
    // last word of the frame
    res.port = r.port;
    res.pad  = PAD_NONE;
    res.cls  = HIT_NONE;
    if (hit_word != 0) begin
      if ((hit_word & (hit_word - 64'd1)) != 0) begin
        res.pad = PAD_MULTI;
        res.cls = HIT_MULTI;
      end else begin
        ch = 0;
        while (ch < 63 && !hit_word[ch]) ch++;
        if (ch < CHANNELS) res.pad = tbl_pad[(r.port % PORTS) * CHANNELS + ch];
        res.cls = HIT_ONE;
      end
    end
    pad_results_due.push_back(res);
    class_seen[res.cls]++;
    word_pos  = '0;
    cur_mask  = '0;
    hit_word  = '0;
    hit_found = 1'b0;
  endtask

  // Input driver: one pending request per accepted slot, random gaps
  always @(posedge clk) begin : drive_proc
    decoder_req_t drive_req;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_reqs.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        drive_req = pending_reqs.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.command   <= drive_req.command;
        in_ch.port      <= drive_req.port;
        in_ch.channel   <= drive_req.channel;
        in_ch.pad_value <= drive_req.pad;
        in_ch.fifo_word <= drive_req.word;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result ready: random stalls, plus a long hold when asked
  always @(posedge clk) begin : ready_proc
    int seen_holds;
    int hold_left;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      seen_holds = 0;
      hold_left  = 0;
    end else begin
      if (hold_requests != seen_holds) begin
        seen_holds = hold_requests;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Monitor: check results, predict from accepted requests, watchdog
  always @(posedge clk) begin : monitor_proc
    decoder_req_t seen_req;
    pad_result_t  exp_res;
    if (!rst_n) begin
      word_pos  = '0;
      cur_mask  = '0;
      hit_word  = '0;
      hit_found = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pad_results_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result port=%0d pad=%0d class=%0d",
                                  out_ch.out_port, out_ch.pad_code, out_ch.hit_class));
        end else begin
          exp_res = pad_results_due.pop_front();
          if (out_ch.out_port !== exp_res.port)
            flag_mismatch($sformatf("out_port %0d, expected %0d",
                                    out_ch.out_port, exp_res.port));
          if (out_ch.pad_code !== exp_res.pad)
            flag_mismatch($sformatf("pad_code %0d, expected %0d",
                                    out_ch.pad_code, exp_res.pad));
          if (out_ch.hit_class !== exp_res.cls)
            flag_mismatch($sformatf("hit_class %0d, expected %0d",
                                    out_ch.hit_class, exp_res.cls));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen_req.command = cmd_t'(in_ch.command);
        seen_req.port    = in_ch.port;
        seen_req.channel = in_ch.channel;
        seen_req.pad     = in_ch.pad_value;
        seen_req.word    = in_ch.fifo_word;
        predict_request(seen_req);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("Timeout: no request moved for %0d cycles, %0d results outstanding",
                 idle_cycles, pad_results_due.size());
        $display("[stuck_masked_hit_pad_decoder] ERROR");
        $finish;
      end
    end
  end

  task automatic post_table(logic [1:0] p, logic [5:0] ch, logic [7:0] pad);
    decoder_req_t r;
    r.command = CMD_TABLE;
    r.port    = p;
    r.channel = ch;
    r.pad     = pad;
    r.word    = {$urandom, $urandom};
    pending_reqs.push_back(r);
    loaded[p % PORTS][ch] = 1'b1;
    queued_items++;
  endtask

  task automatic post_word(logic [1:0] p, logic [63:0] w);
    decoder_req_t r;
    r.command = CMD_FRAME;
    r.port    = p;
    r.channel = 6'($urandom);
    r.pad     = 8'($urandom);
    r.word    = w;
    pending_reqs.push_back(r);
    queued_items++;
  endtask

  function automatic logic [63:0] pick_mask();
    case ($urandom_range(9))
      0, 1, 2, 3: return '0;
      4, 5:       return {$urandom, $urandom};
      6:          return '1;
      7:          return ~(64'd1 << $urandom_range(63));
      default:    return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] pick_word(logic [63:0] mask);
    case ($urandom_range(9))
      0, 1, 2, 3: return {$urandom, $urandom} & mask;
      4, 5:       return 64'd1 << $urandom_range(63);
      6:          return (64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(63));
      7:          return '1;
      default:    return {$urandom, $urandom};
    endcase
  endfunction

  // One frame of random content; loads the table entry a single hit would read
  task automatic queue_frame(int depth);
    logic [63:0] words[$];
    logic [1:0]  ports[$];
    logic [63:0] mask;
    logic [63:0] first_live;
    logic [1:0]  last_port;
    int          fix_ch;
    mask       = pick_mask();
    first_live = '0;
    fix_ch     = -1;
    words.push_back(mask);
    ports.push_back(2'($urandom));
    for (int k = 1; k <= depth; k++) begin
      words.push_back(pick_word(mask));
      ports.push_back(2'($urandom));
      if (first_live == 0) first_live = words[k] & ~mask;
    end
    last_port = ports[depth];
    if (first_live != 0 && (first_live & (first_live - 64'd1)) == 0) begin
      fix_ch = 0;
      while (!first_live[fix_ch]) fix_ch++;
      if (loaded[last_port][fix_ch]) fix_ch = -1;
    end
    for (int k = 0; k <= depth; k++) begin
      if (k == depth && fix_ch >= 0) post_table(last_port, 6'(fix_ch), 8'($urandom));
      if ($urandom_range(99) < 6) post_table(2'($urandom), 6'($urandom), 8'($urandom));
      post_word(ports[k], words[k]);
    end
  endtask

  // Sender pause: everything accepted and answered, then let the pipe drain
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || pad_results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_frame_depth(logic [6:0] d);
    wait_quiet();
    @(posedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= d;
    frame_depth =  d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(int depth, int budget, bit hold);
    int start;
    set_frame_depth(depth[6:0]);
    if (hold) hold_requests++;
    start = queued_items;
    while (queued_items - start < budget) begin
      if ($urandom_range(99) < 10) repeat ($urandom_range(1, 4))
        post_table(2'($urandom), 6'($urandom), 8'($urandom));
      queue_frame(depth);
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.command   = CMD_TABLE;
    in_ch.port      = '0;
    in_ch.channel   = '0;
    in_ch.pad_value = '0;
    in_ch.fifo_word = '0;
    out_ch.ready    = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: table loads at the reset depth
    post_table(2'd0, 6'd0,  8'hFF);
    post_table(2'd3, 6'd63, 8'h3C);
    post_table(2'd1, 6'd5,  8'hA5);
    post_table(2'd2, 6'd40, 8'h5A);

    // Empty frames: the mask word alone ends the frame
    set_frame_depth(7'd0);
    post_word(2'd3, '1);
    post_word(2'd0, '0);

    set_frame_depth(7'd2);
    // lowest channel, ports interleaved
    post_word(2'd1, '0);
    post_word(2'd2, 64'd1);
    post_word(2'd0, '0);
    // highest channel
    post_word(2'd0, '0);
    post_word(2'd1, 64'h8000_0000_0000_0000);
    post_word(2'd3, '1);
    // all but one channel stuck, table reloaded mid-frame
    post_word(2'd2, ~(64'd1 << 5));
    post_word(2'd0, '0);
    post_table(2'd1, 6'd5, 8'h77);
    post_word(2'd1, '1);
    // every channel stuck
    post_word(2'd0, '1);
    post_word(2'd1, '1);
    post_word(2'd2, '1);
    // several channels live
    post_word(2'd0, '0);
    post_word(2'd0, 64'hFFFF_0000_0000_0001);
    post_word(2'd2, '0);
    // first live word wins over a later noisy one
    post_word(2'd3, 64'hF0);
    post_word(2'd3, (64'd1 << 40) | 64'h30);
    post_word(2'd2, '1);

    // Depth lowered mid-frame: the next word closes the frame
    set_frame_depth(7'd5);
    post_word(2'd0, '0);
    post_word(2'd1, '0);
    post_word(2'd2, 64'd1 << 5);
    set_frame_depth(7'd2);
    post_word(2'd1, '0);

    // Random phases over several depths, extremes included
    run_phase(1,   120, 1'b0);
    run_phase(3,   140, 1'b1);
    run_phase(0,    40, 1'b0);
    steady = 1'b1;
    run_phase(7,   140, 1'b0);
    wait_quiet();
    steady = 1'b0;
    run_phase(127,   1, 1'b0);
    run_phase(2,   140, 1'b0);
    run_phase(15,  130, 1'b0);
    run_phase(5,   120, 1'b0);
    run_phase(4,   120, 1'b1);

    // Drain, then give stray results a chance to show up
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || pad_results_due.size() != 0);
    repeat (4 * SETTLE_CYCLES) @(negedge clk);

    $display("Covered %0d table loads and %0d frame words, depths 0 to 127, a mid-frame",
             table_writes, frame_words);
    $display("depth change and long result stalls; results: %0d none, %0d single, %0d multi",
             class_seen[HIT_NONE], class_seen[HIT_ONE], class_seen[HIT_MULTI]);
    if (error_count == 0) begin
      $display("[stuck_masked_hit_pad_decoder] OK");
    end else begin
      $display("[stuck_masked_hit_pad_decoder] ERROR");
    end
    $finish;
  end

endmodule
